// File: src/sha_pkg.sv
// SHA-256 package: round constants, initial hash values and the round helper functions.
// It has no dependencies. The core and the top level import it.
`default_nettype none
package sha_pkg;

  localparam int unsigned BlockBytes  = 64;
  localparam int unsigned DigestWords = 8;

  localparam logic [1:0] FuncStart  = 2'd0;
  localparam logic [1:0] FuncData   = 2'd1;
  localparam logic [1:0] FuncFinish = 2'd2;

  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage
`default_nettype wire

// File: src/sha_core.sv
// SHA-256 compression core: 16-word schedule memory and one round per cycle.
// Depends on sha_pkg. The block words come in through a write port before start.
`default_nettype none
module sha_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 wr_en_i,
  input  wire  [3:0]          wr_addr_i,
  input  wire  sha_pkg::word_t wr_data_i,
  input  wire                 start_i,
  input  wire  sha_pkg::word_t chain_i [8],
  output logic                busy_o,
  output logic                done_o,
  output sha_pkg::word_t      state_o [8]
);
  import sha_pkg::*;

  // Schedule memory: one write and one registered read of w[r-15], w[r-2],
  // w[r-16] and w[r-7]; four reads each round are served by four copies.
  word_t mem_a [16];
  word_t mem_b [16];
  word_t mem_c [16];
  word_t mem_d [16];
  word_t rd_a_q, rd_b_q, rd_c_q, rd_d_q;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRound = 2'd2;
  localparam logic [1:0] StSum = 2'd3;

  logic [1:0] st_q, st_d;
  logic [5:0] rnd_q, rnd_d;
  word_t s_q [8];
  word_t s_d [8];
  word_t w_cur;
  logic       we;
  logic [3:0] waddr;
  word_t      wdata;
  logic [5:0] nr;
  logic [3:0] ra, rb, rc, rd;

  assign nr = rnd_q + 6'd1;
  // Addresses for the round after the one in flight. The word written in
  // round r is first needed as w[r-2] by round r+2, whose read happens
  // after that write, so no forwarding is needed.
  always_comb begin
    if (st_q == StIdle) begin
      ra = 4'd1; rb = 4'd14; rc = 4'd0; rd = 4'd9;
    end else begin
      ra = nr[3:0] + 4'd1; rb = nr[3:0] + 4'd14; rc = nr[3:0]; rd = nr[3:0] + 4'd9;
    end
  end

  always_comb begin
    if (rnd_q < 6'd16) w_cur = rd_c_q;
    else w_cur = sig1(rd_b_q) + sig0(rd_a_q) + rd_c_q + rd_d_q;
  end

  // The w[t-2] operand of round r+1 is w[r-1], the word written at round r-1:
  // the read happens at round r, after the write of round r-1, so no hazard
  // remains.
  always_comb begin
    we = wr_en_i;
    waddr = wr_addr_i;
    wdata = wr_data_i;
    if (st_q == StRound && rnd_q >= 6'd16) begin
      we = 1'b1; waddr = rnd_q[3:0]; wdata = w_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_a[waddr] <= wdata;
      mem_b[waddr] <= wdata;
      mem_c[waddr] <= wdata;
      mem_d[waddr] <= wdata;
    end
    rd_a_q <= mem_a[ra];
    rd_b_q <= mem_b[rb];
    rd_c_q <= mem_c[rc];
    rd_d_q <= mem_d[rd];
  end

  always_comb begin
    word_t t1, t2;
    st_d = st_q;
    rnd_d = rnd_q;
    for (int i = 0; i < 8; i++) s_d[i] = s_q[i];
    t1 = s_q[7] + bsig1(s_q[4]) + ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6]))
         + round_k(rnd_q) + w_cur;
    t2 = bsig0(s_q[0]) + ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));
    case (st_q)
      StIdle: begin
        if (start_i) begin
          st_d = StRound;
          rnd_d = 6'd0;
          for (int i = 0; i < 8; i++) s_d[i] = chain_i[i];
        end
      end
      StRound: begin
        s_d[7] = s_q[6]; s_d[6] = s_q[5]; s_d[5] = s_q[4]; s_d[4] = s_q[3] + t1;
        s_d[3] = s_q[2]; s_d[2] = s_q[1]; s_d[1] = s_q[0]; s_d[0] = t1 + t2;
        rnd_d = nr;
        if (rnd_q == 6'd63) st_d = StSum;
      end
      StSum: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      rnd_q <= 6'd0;
    end else begin
      st_q <= st_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) s_q[i] <= s_d[i];
  end

  assign busy_o = (st_q != StIdle);
  assign done_o = (st_q == StSum);
  always_comb for (int i = 0; i < 8; i++) state_o[i] = s_q[i];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> st_q == StIdle) else $error("start while busy");
  a_sum_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRound && rnd_q == 6'd63) |=> st_q == StSum) else $error("no sum");
  a_no_ext_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> st_q != StRound) else $error("write during rounds");
endmodule
`default_nettype wire

// File: src/sha256_stream_hasher_top.sv
// Top level of the streaming SHA-256 hasher: byte packing, padding, chaining, digest.
// Depends on sha_pkg and sha_core.
//
// Channel   Direction  Signals
// in        input      in_valid_i, in_ready_o, func_i, data_byte_i
// out       output     out_valid_o, out_ready_i, digest_word_o, word_index_o, last_word_o
//
// Every 64th data byte starts a compression (64 rounds by the single round unit and
// a final add; the first schedule read overlaps the start edge). No byte is accepted
// while the core runs. Finish writes one padding word per cycle while the core is idle,
// from the word that holds the fill point up to word 15, then waits for the compression;
// when the length spills over, 16 more padding words and a second compression follow.
// Eight output words then leave at one per cycle when out_ready_i is high; input stalls
// meanwhile.
// Reset leaves the state of a fresh start: initial hash values, zero count.
`default_nettype none
module sha256_stream_hasher_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  func_i,
  input  wire  [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StComp  = 3'd1;  // waiting on core
  localparam logic [2:0] StPad   = 3'd2;  // write padding words
  localparam logic [2:0] StPad2  = 3'd3;  // second padding block
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]  st_q, st_d;
  word_t       chain_q [8];
  logic [63:0] cnt_q;
  logic [5:0]  fill_q;
  logic        fin_q;
  logic [23:0] part_q;        // pending high bytes of the current word
  logic [3:0]  pw_q;          // padding word pointer
  logic        two_q;         // second block still to go after this one
  logic [2:0]  oi_q;

  logic        core_wr;
  logic [3:0]  core_addr;
  word_t       core_data;
  logic        core_start, core_busy, core_done;
  word_t       core_st [8];

  sha_core u_core (
    .clk_i, .rst_ni,
    .wr_en_i(core_wr), .wr_addr_i(core_addr), .wr_data_i(core_data),
    .start_i(core_start), .chain_i(chain_q),
    .busy_o(core_busy), .done_o(core_done), .state_o(core_st)
  );

  logic acc_in, acc_out, is_data, blk_end;
  assign in_ready_o = (st_q == StIdle) && !(core_busy);
  assign acc_in = in_valid_i && in_ready_o;
  assign acc_out = out_valid_o && out_ready_i;
  assign is_data = acc_in && func_i == FuncData && !fin_q;
  assign blk_end = fill_q == 6'd63;

  // Padding word at word pointer pw for the current fill (only when two_q=0
  // the length goes in the last two words). First pad block: partial word
  // holds bytes, then 0x80, then zeros.
  word_t pad_w;
  logic [63:0] bits;
  assign bits = {cnt_q[60:0], 3'b000};
  always_comb begin
    logic [3:0] fw;
    logic [1:0] fb;
    fw = fill_q[5:2];
    fb = fill_q[1:0];
    pad_w = '0;
    if (st_q == StPad) begin
      if (pw_q == fw) begin
        case (fb)
          2'd0: pad_w = {PadByte, 24'h0};
          2'd1: pad_w = {part_q[7:0], PadByte, 16'h0};
          2'd2: pad_w = {part_q[15:0], PadByte, 8'h0};
          2'd3: pad_w = {part_q[23:0], PadByte};
          default: pad_w = '0;
        endcase
      end
    end
    if (!two_q || st_q == StPad2) begin
      if (pw_q == 4'd14) pad_w = bits[63:32];
      if (pw_q == 4'd15) pad_w = bits[31:0];
    end
  end

  always_comb begin
    core_wr = 1'b0; core_addr = fill_q[5:2]; core_data = {part_q, data_byte_i};
    core_start = 1'b0;
    if (is_data && fill_q[1:0] == 2'd3) core_wr = 1'b1;
    if (is_data && blk_end) core_start = 1'b1;
    if ((st_q == StPad || st_q == StPad2) && !core_busy) begin
      core_wr = 1'b1; core_addr = pw_q; core_data = pad_w;
      if (pw_q == 4'd15) core_start = 1'b1;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: begin
        if (acc_in && func_i == FuncFinish) st_d = fin_q ? StOut : StPad;
      end
      StPad: if (!core_busy && pw_q == 4'd15) st_d = StComp;
      StPad2: if (!core_busy && pw_q == 4'd15) st_d = StComp;
      StComp: if (core_done) st_d = two_q ? StPad2 : StOut;
      StOut: if (acc_out && oi_q == 3'd7) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; fill_q <= '0; fin_q <= 1'b0;
      pw_q <= '0; two_q <= 1'b0; oi_q <= '0;
      for (int i = 0; i < 8; i++) chain_q[i] <= init_hash(3'(i));
    end else begin
      st_q <= st_d;
      if (core_done) for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + core_st[i];
      if (acc_in && func_i == FuncStart) begin
        cnt_q <= '0; fill_q <= '0; fin_q <= 1'b0;
        for (int i = 0; i < 8; i++) chain_q[i] <= init_hash(3'(i));
      end
      if (is_data) begin
        cnt_q <= cnt_q + 64'd1;
        fill_q <= fill_q + 6'd1;
      end
      // Words below the fill point already hold message bytes, so padding
      // starts at the word that holds the fill point.
      if (acc_in && func_i == FuncFinish && !fin_q) begin
        fin_q <= 1'b1;
        pw_q <= fill_q[5:2];
        two_q <= fill_q > 6'd55;
      end
      if ((st_q == StPad || st_q == StPad2) && !core_busy) pw_q <= pw_q + 4'd1;
      if (st_q == StComp && core_done && two_q) two_q <= 1'b0;
      if (acc_out) oi_q <= oi_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_data) part_q <= {part_q[15:0], data_byte_i};
  end

  assign out_valid_o = (st_q == StOut);
  assign digest_word_o = chain_q[oi_q];
  assign word_index_o = oi_q;
  assign last_word_o = (oi_q == 3'd7);

  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during digest");
  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == cnt_q[5:0]) else $error("fill and count disagree");
  a_block_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_data && blk_end) |=> core_busy) else $error("block not compressed");
endmodule
`default_nettype wire
